// ===== hdl/sh_integer_alu_with_t_flag_core_assert.svh =====
// assertion macros used by the checker file
`ifndef SH_INTEGER_ALU_WITH_T_FLAG_CORE_ASSERT_SVH
`define SH_INTEGER_ALU_WITH_T_FLAG_CORE_ASSERT_SVH

// checked only outside reset
`define SIAT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked in reset too
`define SIAT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/siat_pkg.sv =====
// ----------------------------------------------------------------------------
// siat_pkg
// operation codes and the stage record of the integer alu
// ----------------------------------------------------------------------------
package siat_pkg;

    localparam logic [5:0] OP_ADD    = 6'd0;
    localparam logic [5:0] OP_ADDC   = 6'd1;
    localparam logic [5:0] OP_ADDV   = 6'd2;
    localparam logic [5:0] OP_SUB    = 6'd3;
    localparam logic [5:0] OP_SUBC   = 6'd4;
    localparam logic [5:0] OP_SUBV   = 6'd5;
    localparam logic [5:0] OP_NEG    = 6'd6;
    localparam logic [5:0] OP_NEGC   = 6'd7;
    localparam logic [5:0] OP_AND    = 6'd8;
    localparam logic [5:0] OP_OR     = 6'd9;
    localparam logic [5:0] OP_XOR    = 6'd10;
    localparam logic [5:0] OP_NOT    = 6'd11;
    localparam logic [5:0] OP_TST    = 6'd12;
    localparam logic [5:0] OP_CMPEQ  = 6'd13;
    localparam logic [5:0] OP_CMPHS  = 6'd14;
    localparam logic [5:0] OP_CMPGE  = 6'd15;
    localparam logic [5:0] OP_CMPHI  = 6'd16;
    localparam logic [5:0] OP_CMPGT  = 6'd17;
    localparam logic [5:0] OP_CMPPL  = 6'd18;
    localparam logic [5:0] OP_CMPPZ  = 6'd19;
    localparam logic [5:0] OP_CMPSTR = 6'd20;
    localparam logic [5:0] OP_DT     = 6'd21;
    localparam logic [5:0] OP_ROTL   = 6'd22;
    localparam logic [5:0] OP_ROTR   = 6'd23;
    localparam logic [5:0] OP_ROTCL  = 6'd24;
    localparam logic [5:0] OP_ROTCR  = 6'd25;
    localparam logic [5:0] OP_SHAL   = 6'd26;
    localparam logic [5:0] OP_SHAR   = 6'd27;
    localparam logic [5:0] OP_SHLL   = 6'd28;
    localparam logic [5:0] OP_SHLR   = 6'd29;
    localparam logic [5:0] OP_SHLL2  = 6'd30;
    localparam logic [5:0] OP_SHLR2  = 6'd31;
    localparam logic [5:0] OP_SHLL8  = 6'd32;
    localparam logic [5:0] OP_SHLR8  = 6'd33;
    localparam logic [5:0] OP_SHLL16 = 6'd34;
    localparam logic [5:0] OP_SHLR16 = 6'd35;
    localparam logic [5:0] OP_SHAD   = 6'd36;
    localparam logic [5:0] OP_SHLD   = 6'd37;
    localparam logic [5:0] OP_EXTSB  = 6'd38;
    localparam logic [5:0] OP_EXTSW  = 6'd39;
    localparam logic [5:0] OP_EXTUB  = 6'd40;
    localparam logic [5:0] OP_EXTUW  = 6'd41;
    localparam logic [5:0] OP_SWAPB  = 6'd42;
    localparam logic [5:0] OP_SWAPW  = 6'd43;
    localparam logic [5:0] OP_XTRCT  = 6'd44;
    localparam logic [5:0] OP_DIV0U  = 6'd45;
    localparam logic [5:0] OP_DIV0S  = 6'd46;
    localparam logic [5:0] OP_DIV1   = 6'd47;
    localparam logic [5:0] OP_MULL   = 6'd48;
    localparam logic [5:0] OP_MULSW  = 6'd49;
    localparam logic [5:0] OP_MULUW  = 6'd50;
    localparam logic [5:0] OP_DMULS  = 6'd51;
    localparam logic [5:0] OP_DMULU  = 6'd52;
    localparam logic [5:0] OP_MAC    = 6'd53;
    localparam logic [5:0] OP_CLRT   = 6'd54;
    localparam logic [5:0] OP_SETT   = 6'd55;
    localparam logic [5:0] OP_CLRMAC = 6'd56;
    localparam logic [5:0] OP_MOVT   = 6'd57;
    localparam logic [5:0] OP_MOV    = 6'd58;

    localparam logic [31:0] SIGN32 = 32'h8000_0000;

    // one operation in flight between the stages
    typedef struct packed {
        logic        valid;
        logic [5:0]  op;
        logic [31:0] src;
        logic [31:0] dst;
        logic [63:0] prod;
    } stage_t;

endpackage

// ===== hdl/siat_mul.sv =====
// ----------------------------------------------------------------------------
// siat_mul
// input register and multiplier stage
// ----------------------------------------------------------------------------
module siat_mul
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [5:0]         in_op,
    input  logic [31:0]        in_src,
    input  logic [31:0]        in_dst,
    output siat_pkg::stage_t   stg
);

    logic        v1_reg;
    logic [5:0]  op1_reg;
    logic [31:0] s1_reg;
    logic [31:0] d1_reg;
    logic [32:0] ma;
    logic [32:0] mb;
    logic [65:0] mp;
    logic        v2_reg;
    logic [5:0]  op2_reg;
    logic [31:0] s2_reg;
    logic [31:0] d2_reg;
    logic [63:0] p2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg <= in_op;
            s1_reg  <= in_src;
            d1_reg  <= in_dst;
            op2_reg <= op1_reg;
            s2_reg  <= s1_reg;
            d2_reg  <= d1_reg;
            p2_reg  <= mp[63:0];
        end
    end

    // operand forms: 16-bit signed, 16-bit unsigned, 32-bit signed, 32-bit unsigned
    always_comb
    begin
        case (op1_reg)
            siat_pkg::OP_MULSW:
            begin
                ma = {{17{s1_reg[15]}}, s1_reg[15:0]};
                mb = {{17{d1_reg[15]}}, d1_reg[15:0]};
            end
            siat_pkg::OP_MULUW:
            begin
                ma = {17'd0, s1_reg[15:0]};
                mb = {17'd0, d1_reg[15:0]};
            end
            siat_pkg::OP_DMULS, siat_pkg::OP_MAC:
            begin
                ma = {s1_reg[31], s1_reg};
                mb = {d1_reg[31], d1_reg};
            end
            default:
            begin
                ma = {1'b0, s1_reg};
                mb = {1'b0, d1_reg};
            end
        endcase
    end

    assign mp  = 66'($signed(ma) * $signed(mb));
    assign stg = {v2_reg, op2_reg, s2_reg, d2_reg, p2_reg};

endmodule

// ===== hdl/siat_exec.sv =====
// ----------------------------------------------------------------------------
// siat_exec
// alu, status bits, accumulator and result register
// ----------------------------------------------------------------------------
module siat_exec
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  siat_pkg::stage_t  stg,
    output logic              out_valid,
    output logic [31:0]       out_result,
    output logic              out_t,
    output logic [31:0]       out_mach,
    output logic [31:0]       out_macl
);

    logic        t_reg, m_reg, q_reg;
    logic [31:0] mach_reg, macl_reg;
    logic        t_next, m_next, q_next;
    logic [31:0] mach_next, macl_next;
    logic [31:0] r;
    logic        vout_reg;
    logic [31:0] res_reg;
    logic [31:0] s, d, x;
    logic [32:0] w;
    logic [4:0]  sh;
    logic [4:0]  rsh;
    logic        nq, cy;
    logic [31:0] a;
    logic [63:0] acc;

    assign s = stg.src;
    assign d = stg.dst;

    always_comb
    begin
        r         = d;
        t_next    = t_reg;
        m_next    = m_reg;
        q_next    = q_reg;
        mach_next = mach_reg;
        macl_next = macl_reg;
        x         = d ^ s;
        w         = 33'd0;
        sh        = s[4:0];
        rsh       = 5'(~sh + 5'd1);
        nq        = d[31];
        a         = {d[30:0], t_reg};
        cy        = 1'b0;
        acc       = {mach_reg, macl_reg} + stg.prod;
        case (stg.op)
            siat_pkg::OP_ADD:  r = d + s;
            siat_pkg::OP_ADDC:
            begin
                w = {1'b0, d} + {1'b0, s} + {32'd0, t_reg};
                r = w[31:0];
                t_next = w[32];
            end
            siat_pkg::OP_ADDV:
            begin
                r = d + s;
                t_next = ~x[31] & (d[31] ^ r[31]);
            end
            siat_pkg::OP_SUB:  r = d - s;
            siat_pkg::OP_SUBC:
            begin
                w = {1'b0, d} - {1'b0, s} - {32'd0, t_reg};
                r = w[31:0];
                t_next = w[32];
            end
            siat_pkg::OP_SUBV:
            begin
                r = d - s;
                t_next = x[31] & (d[31] ^ r[31]);
            end
            siat_pkg::OP_NEG:  r = 32'd0 - s;
            siat_pkg::OP_NEGC:
            begin
                w = 33'd0 - {1'b0, s} - {32'd0, t_reg};
                r = w[31:0];
                t_next = w[32];
            end
            siat_pkg::OP_AND:    r = d & s;
            siat_pkg::OP_OR:     r = d | s;
            siat_pkg::OP_XOR:    r = x;
            siat_pkg::OP_NOT:    r = ~s;
            siat_pkg::OP_TST:    t_next = ((s & d) == 32'd0);
            siat_pkg::OP_CMPEQ:  t_next = (d == s);
            siat_pkg::OP_CMPHS:  t_next = (d >= s);
            siat_pkg::OP_CMPGE:  t_next = ($signed(d) >= $signed(s));
            siat_pkg::OP_CMPHI:  t_next = (d > s);
            siat_pkg::OP_CMPGT:  t_next = ($signed(d) > $signed(s));
            siat_pkg::OP_CMPPL:  t_next = !s[31] && (s != 32'd0);
            siat_pkg::OP_CMPPZ:  t_next = !s[31];
            siat_pkg::OP_CMPSTR:
                t_next = (x[31:24] == 8'd0) || (x[23:16] == 8'd0) ||
                         (x[15:8] == 8'd0) || (x[7:0] == 8'd0);
            siat_pkg::OP_DT:
            begin
                r = d - 32'd1;
                t_next = (r == 32'd0);
            end
            siat_pkg::OP_ROTL:
            begin
                r = {d[30:0], d[31]};
                t_next = d[31];
            end
            siat_pkg::OP_ROTR:
            begin
                r = {d[0], d[31:1]};
                t_next = d[0];
            end
            siat_pkg::OP_ROTCL:
            begin
                r = {s[30:0], t_reg};
                t_next = s[31];
            end
            siat_pkg::OP_ROTCR:
            begin
                r = {t_reg, d[31:1]};
                t_next = d[0];
            end
            siat_pkg::OP_SHAL:
            begin
                r = {d[30:0], 1'b0};
                t_next = d[31];
            end
            siat_pkg::OP_SHAR:
            begin
                r = {d[31], d[31:1]};
                t_next = d[0];
            end
            siat_pkg::OP_SHLL:
            begin
                r = {s[30:0], 1'b0};
                t_next = s[31];
            end
            siat_pkg::OP_SHLR:
            begin
                r = {1'b0, d[31:1]};
                t_next = d[0];
            end
            siat_pkg::OP_SHLL2:  r = s << 2;
            siat_pkg::OP_SHLR2:  r = d >> 2;
            siat_pkg::OP_SHLL8:  r = s << 8;
            siat_pkg::OP_SHLR8:  r = d >> 8;
            siat_pkg::OP_SHLL16: r = s << 16;
            siat_pkg::OP_SHLR16: r = d >> 16;
            siat_pkg::OP_SHAD:
            begin
                // negative amount with zero low bits shifts right by a full word
                if (!s[31])
                    r = d << sh;
                else if (sh == 5'd0)
                    r = {32{d[31]}};
                else
                    r = 32'($signed(d) >>> rsh);
            end
            siat_pkg::OP_SHLD:
            begin
                if (!s[31])
                    r = d << sh;
                else if (sh == 5'd0)
                    r = 32'd0;
                else
                    r = d >> rsh;
            end
            siat_pkg::OP_EXTSB:  r = {{24{s[7]}}, s[7:0]};
            siat_pkg::OP_EXTSW:  r = {{16{s[15]}}, s[15:0]};
            siat_pkg::OP_EXTUB:  r = {24'd0, s[7:0]};
            siat_pkg::OP_EXTUW:  r = {16'd0, s[15:0]};
            siat_pkg::OP_SWAPB:  r = {s[31:16], s[7:0], s[15:8]};
            siat_pkg::OP_SWAPW:  r = {s[15:0], s[31:16]};
            siat_pkg::OP_XTRCT:  r = {s[15:0], d[31:16]};
            siat_pkg::OP_DIV0U:
            begin
                m_next = 1'b0;
                q_next = 1'b0;
                t_next = 1'b0;
            end
            siat_pkg::OP_DIV0S:
            begin
                q_next = d[31];
                m_next = s[31];
                t_next = d[31] ^ s[31];
            end
            siat_pkg::OP_DIV1:
            begin
                if (q_reg == m_reg)
                    w = {1'b0, a} - {1'b0, s};
                else
                    w = {1'b0, a} + {1'b0, s};
                r = w[31:0];
                cy = w[32];
                q_next = nq ^ cy ^ m_reg;
                t_next = (q_next == m_reg);
            end
            siat_pkg::OP_MULL, siat_pkg::OP_MULSW, siat_pkg::OP_MULUW:
                macl_next = stg.prod[31:0];
            siat_pkg::OP_DMULS, siat_pkg::OP_DMULU:
            begin
                mach_next = stg.prod[63:32];
                macl_next = stg.prod[31:0];
            end
            siat_pkg::OP_MAC:
            begin
                mach_next = acc[63:32];
                macl_next = acc[31:0];
            end
            siat_pkg::OP_CLRT:   t_next = 1'b0;
            siat_pkg::OP_SETT:   t_next = 1'b1;
            siat_pkg::OP_CLRMAC:
            begin
                mach_next = 32'd0;
                macl_next = 32'd0;
            end
            siat_pkg::OP_MOVT:   r = {31'd0, t_reg};
            siat_pkg::OP_MOV:    r = s;
            default:             r = d;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg    <= 1'b0;
            m_reg    <= 1'b0;
            q_reg    <= 1'b0;
            mach_reg <= 32'd0;
            macl_reg <= 32'd0;
            vout_reg <= 1'b0;
        end
        else if (adv)
        begin
            vout_reg <= stg.valid;
            if (stg.valid)
            begin
                t_reg    <= t_next;
                m_reg    <= m_next;
                q_reg    <= q_next;
                mach_reg <= mach_next;
                macl_reg <= macl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && stg.valid)
            res_reg <= r;
    end

    assign out_valid  = vout_reg;
    assign out_result = res_reg;
    assign out_t      = t_reg;
    assign out_mach   = mach_reg;
    assign out_macl   = macl_reg;

endmodule

// ===== hdl/sh_integer_alu_with_t_flag_core.sv =====
// result path: an accepted input passes the input register, the multiply stage and the execute result register in turn
// throughput: one operation per cycle; t, m, q and the accumulator feed the next operation
// the whole pipe stalls only while a result waits and m_tready is low
// reset: rst_n low clears the valid bits, t, m, q and mach:macl at once
// ----------------------------------------------------------------------------
// sh_integer_alu_with_t_flag_core
// superh-style integer execute unit with t flag and mac accumulator
// ----------------------------------------------------------------------------
module sh_integer_alu_with_t_flag_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [71:0]   s_tdata,   // req_type[5:0], src_value[37:6], dst_value[69:38]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata    // result[31:0], t_out[32], mach_out[64:33], macl_out[96:65]
);

    logic             adv;
    siat_pkg::stage_t stg;
    logic [31:0]      res, mach, macl;
    logic             t;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    siat_mul u_mul
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s_tvalid),
        .in_op    (s_tdata[5:0]),
        .in_src   (s_tdata[37:6]),
        .in_dst   (s_tdata[69:38]),
        .stg      (stg)
    );

    siat_exec u_exec
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .stg        (stg),
        .out_valid  (m_tvalid),
        .out_result (res),
        .out_t      (t),
        .out_mach   (mach),
        .out_macl   (macl)
    );

    assign m_tdata = {7'd0, macl, mach, t, res};

endmodule

// ===== hdl/siat_checker.sv =====
// ----------------------------------------------------------------------------
// siat_checker
// port-level checks of the integer alu
// ----------------------------------------------------------------------------
`include "sh_integer_alu_with_t_flag_core_assert.svh"

module siat_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic [71:0]   s_tdata,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [103:0]  m_tdata
);

    // a waiting result keeps its payload
    `SIAT_ASSERT(a_hold, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
    // input side opens exactly when the result register can move
    `SIAT_ASSERT(a_ready, s_tready == (!m_tvalid || m_tready), "ready does not follow output")
    `SIAT_ASSERT_RST(a_rst, !rst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind sh_integer_alu_with_t_flag_core siat_checker u_siat_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
